// ===== rtl/imhtq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhtq_pkg: shared types and constants for the timer heap queue
// Holds operation and status codes, the controller state type and the
// command / status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package imhtq_pkg;

  localparam int unsigned NumTimersDefault = 256;
  localparam int unsigned TimeBitsDefault  = 64;
  localparam int unsigned IdW              = 8;
  localparam int unsigned FieldTimeW       = 64;
  localparam int unsigned CountW           = 9;
  localparam int unsigned StatusW          = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REKEY  = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a beat
    S_LOOKUP,   // read position / valid of id
    S_DECIDE,   // pick the operation path
    S_REM_LAST, // read id at the last slot
    S_REM_MOVE, // move last entry into the hole
    S_UP_RD,    // read parent key
    S_UP_CMP,   // compare and maybe swap with parent
    S_DN_RD,    // read children keys
    S_DN_CMP,   // compare and maybe swap with child
    S_INS,      // place new id at the end
    S_HEAD_RD,  // read head slot and time
    S_HEAD_WT,  // head data settles
    S_OUT       // result waits for the sink
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic lookup;
    logic rem_last_rd;
    logic rem_move;
    logic up_init_pos;
    logic up_rd;
    logic up_step;
    logic dn_rd;
    logic dn_step;
    logic ins;
    logic head_rd;
    logic set_status;
    logic set_result;
    logic clr_moved;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       present;
    logic       in_range;
    logic       last_is_hole;
    logic       up_at_root;
    logic       up_swap;
    logic       moved;
    logic       dn_no_child;
    logic       dn_swap;
  } stat_t;

endpackage

// ===== rtl/indexed_min_heap_timer_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue: indexed binary min-heap of timers
// Top level joining the sequencer and the heap datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per beat: insert, remove, rekey or an
//   expiry check of the head against the current time. m_axis returns one
//   beat per operation with status, head id / time, expiry flag and count.
//   Operations are handled one at a time. A check or a rejected operation
//   goes through lookup, decision and head read; an insert adds its
//   placement and a sift-up compare per level, a removal adds its last-slot
//   read and move, its sift-up check and a sift-down compare per level,
//   each level bound by the registered slot and time memory reads.
//   Reset clears the count and every id's valid bit at once; no clearing
//   pass is needed. While the sink holds m_axis_tready low the result beat
//   stays stable and no new operation is taken.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue
  import imhtq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDefault,
  parameter int unsigned TIME_BITS  = TimeBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [9:2] tmr_id, [73:10] trigger_time, [137:74] now_ms
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [3] head_valid, [11:4] head_id, [75:12] head_time,
  // [76] head_expired, [85:77] count
  output logic [87:0]  m_axis_tdata
);

  cmd_t                  cmd;
  stat_t                 stat;
  logic [StatusW-1:0]    status;
  logic [StatusW-1:0]    r_status;
  logic                  r_hv, r_exp;
  logic [IdW-1:0]        r_hid;
  logic [FieldTimeW-1:0] r_ht;
  logic [CountW-1:0]     r_cnt;

  imhtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .status_o   (status)
  );

  imhtq_datapath #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_op_i           (s_axis_tdata[1:0]),
    .in_id_i           (s_axis_tdata[9:2]),
    .in_trig_i         (s_axis_tdata[73:10]),
    .in_now_i          (s_axis_tdata[137:74]),
    .status_i          (status),
    .res_status_o      (r_status),
    .res_head_valid_o  (r_hv),
    .res_head_id_o     (r_hid),
    .res_head_time_o   (r_ht),
    .res_head_expired_o(r_exp),
    .res_count_o       (r_cnt)
  );

  // pack the result beat
  assign m_axis_tdata = {2'b00, r_cnt, r_exp, r_ht, r_hid, r_hv, r_status};

endmodule

// ===== rtl/imhtq_datapath.sv =====
// ----------------------------------------------------------------------------
// imhtq_datapath: heap memories, position map and sift registers
// Slot memory, time-of-id memory and position map, each with registered
// reads; one sift step (read, compare, swap) per command pair.
// ----------------------------------------------------------------------------
module imhtq_datapath
  import imhtq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = NumTimersDefault,
  parameter int unsigned TIME_BITS  = TimeBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [1:0]            in_op_i,
  input  logic [IdW-1:0]        in_id_i,
  input  logic [FieldTimeW-1:0] in_trig_i,
  input  logic [FieldTimeW-1:0] in_now_i,
  input  logic [StatusW-1:0]    status_i,
  output logic [StatusW-1:0]    res_status_o,
  output logic                  res_head_valid_o,
  output logic [IdW-1:0]        res_head_id_o,
  output logic [FieldTimeW-1:0] res_head_time_o,
  output logic                  res_head_expired_o,
  output logic [CountW-1:0]     res_count_o
);

  localparam int unsigned PosW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned MapW = (IdW > PosW) ? PosW : IdW;

  // storage
  logic [PosW-1:0]      slot_mem [NUM_TIMERS];
  logic [TIME_BITS-1:0] time_mem [NUM_TIMERS];
  logic [PosW-1:0]      pos_mem  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid_q;
  logic [CntW-1:0]      count_q;

  // latched item
  logic [1:0]           op_q;
  logic [IdW-1:0]       id_q;
  logic [TIME_BITS-1:0] trig_q, now_q;
  logic                 in_range_q;
  logic [PosW-1:0]      map_idx;

  // sift state
  logic [PosW-1:0]      p_q;      // current position
  logic [PosW-1:0]      pid_q;    // id at current position
  logic [TIME_BITS-1:0] pkey_q;   // key at current position
  logic [PosW-1:0]      qid_q;    // id at partner position
  logic [TIME_BITS-1:0] qkey_q;
  logic [PosW-1:0]      rid_q;    // right child id
  logic [TIME_BITS-1:0] rkey_q;
  logic                 has_r_q;
  logic [PosW-1:0]      hole_pos_q;
  logic                 moved_q;
  logic [PosW-1:0]      rd_id_q;  // registered slot read
  logic [PosW-1:0]      rd2_id_q;
  logic [PosW-1:0]      rd_pos_q;
  logic [PosW:0]        lc, rc;
  logic [PosW-1:0]      parent;
  logic [PosW-1:0]      last_pos;
  logic [2:0]           dn_phase_q;
  logic                 up_phase_q;

  // result registers
  logic [StatusW-1:0]    res_status_q;
  logic                  res_hv_q, res_exp_q;
  logic [IdW-1:0]        res_hid_q;
  logic [FieldTimeW-1:0] res_ht_q;
  logic [CountW-1:0]     res_cnt_q;
  logic [TIME_BITS-1:0]  head_time_rd_q;
  logic [PosW-1:0]       head_id_rd_q;

  assign parent   = PosW'((p_q - PosW'(1)) >> 1);
  assign lc       = {p_q, 1'b1};
  assign rc       = lc + (PosW+1)'(1);
  assign last_pos = PosW'(count_q - CntW'(1));

  // in-range id as map index
  always_comb begin
    map_idx = PosW'(id_q[MapW-1:0]);
  end

  // status back to the controller
  always_comb begin
    stat_o.op           = op_q;
    stat_o.full         = (count_q == CntW'(NUM_TIMERS));
    stat_o.empty        = (count_q == '0);
    stat_o.in_range     = in_range_q;
    stat_o.present      = in_range_q && valid_q[map_idx];
    stat_o.last_is_hole = (rd_pos_q == last_pos);
    stat_o.up_at_root   = (p_q == '0);
    stat_o.up_swap      = (qkey_q > pkey_q);
    stat_o.moved        = moved_q;
    stat_o.dn_no_child  = ((PosW+1)'(count_q) <= lc);
    stat_o.dn_swap      = has_r_q && (qkey_q > rkey_q) ? (pkey_q > rkey_q)
                                                       : (pkey_q > qkey_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      moved_q <= 1'b0;
    end else begin
      if (cmd_i.clr_moved) moved_q <= 1'b0;
      if (cmd_i.rem_last_rd) begin
        valid_q[map_idx] <= 1'b0;
        count_q          <= count_q - CntW'(1);
      end
      if (cmd_i.ins) begin
        valid_q[map_idx] <= 1'b1;
        count_q          <= count_q + CntW'(1);
      end
      if (cmd_i.up_step && stat_o.up_swap) moved_q <= 1'b1;
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q       <= in_op_i;
      id_q       <= in_id_i;
      trig_q     <= in_trig_i[TIME_BITS-1:0];
      now_q      <= in_now_i[TIME_BITS-1:0];
      in_range_q <= (32'(in_id_i) < NUM_TIMERS);
    end
    if (cmd_i.lookup) rd_pos_q <= pos_mem[map_idx];
    // with the count decrement: rd_pos_q is the hole, read last slot
    if (cmd_i.rem_last_rd) begin
      rd_id_q    <= slot_mem[PosW'(count_q - CntW'(1))];
      hole_pos_q <= rd_pos_q;
    end
    if (cmd_i.rem_move) begin
      slot_mem[hole_pos_q] <= rd_id_q;
      pos_mem[rd_id_q]     <= hole_pos_q;
      p_q                  <= hole_pos_q;
      pid_q                <= rd_id_q;
      pkey_q               <= time_mem[rd_id_q];
    end
    if (cmd_i.ins) begin
      time_mem[map_idx]                 <= trig_q;
      slot_mem[PosW'(count_q)]          <= map_idx;
      pos_mem[map_idx]                  <= PosW'(count_q);
      p_q                               <= PosW'(count_q);
      pid_q                             <= map_idx;
      pkey_q                            <= trig_q;
    end
    // sift-up read: parent id then its key (two phases)
    if (cmd_i.up_rd) begin
      if (!up_phase_q) qid_q <= slot_mem[parent];
      else             qkey_q <= time_mem[qid_q];
      up_phase_q <= ~up_phase_q;
    end else begin
      up_phase_q <= 1'b0;
    end
    if (cmd_i.up_step && stat_o.up_swap) begin
      slot_mem[parent] <= pid_q;
      slot_mem[p_q]    <= qid_q;
      pos_mem[pid_q]   <= parent;
      pos_mem[qid_q]   <= p_q;
      p_q              <= parent;
    end
    // sift-down read: left id, right id, left key, right key
    if (cmd_i.dn_rd) begin
      case (dn_phase_q)
        3'd0: qid_q <= slot_mem[lc[PosW-1:0]];
        3'd1: begin
          rid_q   <= slot_mem[rc[PosW-1:0]];
          has_r_q <= (rc < (PosW+1)'(count_q));
        end
        3'd2: qkey_q <= time_mem[qid_q];
        default: rkey_q <= time_mem[rid_q];
      endcase
      dn_phase_q <= dn_phase_q + 3'd1;
    end else begin
      dn_phase_q <= 3'd0;
    end
    if (cmd_i.dn_step && stat_o.dn_swap) begin
      if (has_r_q && (qkey_q > rkey_q)) begin
        slot_mem[p_q]           <= rid_q;
        slot_mem[rc[PosW-1:0]]  <= pid_q;
        pos_mem[rid_q]          <= p_q;
        pos_mem[pid_q]          <= rc[PosW-1:0];
        p_q                     <= rc[PosW-1:0];
      end else begin
        slot_mem[p_q]           <= qid_q;
        slot_mem[lc[PosW-1:0]]  <= pid_q;
        pos_mem[qid_q]          <= p_q;
        pos_mem[pid_q]          <= lc[PosW-1:0];
        p_q                     <= lc[PosW-1:0];
      end
    end
    // head read: slot 0 then its time
    if (cmd_i.head_rd) head_id_rd_q <= slot_mem[0];
    head_time_rd_q <= time_mem[head_id_rd_q];
    rd2_id_q <= head_id_rd_q;
    if (cmd_i.set_status) res_status_q <= status_i;
    if (cmd_i.set_result) begin
      res_hv_q  <= (count_q != '0);
      res_hid_q <= (count_q != '0) ? IdW'(rd2_id_q) : '0;
      res_ht_q  <= (count_q != '0) ? FieldTimeW'(head_time_rd_q) : '0;
      res_exp_q <= (count_q != '0) && (op_q == OP_CHECK) &&
                   (head_time_rd_q <= now_q);
      res_cnt_q <= CountW'(count_q);
    end
  end

  assign res_status_o       = res_status_q;
  assign res_head_valid_o   = res_hv_q;
  assign res_head_id_o      = res_hid_q;
  assign res_head_time_o    = res_ht_q;
  assign res_head_expired_o = res_exp_q;
  assign res_count_o        = res_cnt_q;

  // a heap never holds more entries than it has slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NUM_TIMERS))
    else $error("heap count overflow");
  // inserting never happens into a full heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> count_q < CntW'(NUM_TIMERS))
    else $error("insert into full heap");
  // removing only from a non-empty heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rem_last_rd |-> count_q != '0)
    else $error("remove from empty heap");

endmodule

// ===== rtl/imhtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhtq_ctrl: operation sequencer for the timer heap queue
// Walks lookup, removal, sift up / down, insert and head read; holds the
// result until the sink takes it.
// ----------------------------------------------------------------------------
module imhtq_ctrl
  import imhtq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  stat_t              stat_i,
  output cmd_t               cmd_o,
  output logic [StatusW-1:0] status_o
);

  state_e state_q, state_d;
  logic   rekey_ins_q, rekey_ins_d;
  logic [1:0] cnt_q, cnt_d;
  logic   ins_done_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rekey_ins_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      rekey_ins_q <= rekey_ins_d;
      cnt_q       <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    rekey_ins_d = rekey_ins_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    status_o    = ST_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup    = 1'b1;
        cmd_o.clr_moved = 1'b1;
        rekey_ins_d     = 1'b0;
        state_d         = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.set_status = 1'b1;
        state_d          = S_HEAD_RD;
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full)          status_o = ST_FULL;
            else if (!stat_i.in_range) status_o = ST_ABSENT;
            else if (stat_i.present)  status_o = ST_PRESENT;
            else                      state_d  = S_INS;
          end
          OP_REMOVE, OP_REKEY: begin
            if (stat_i.empty)         status_o = ST_EMPTY;
            else if (!stat_i.present) status_o = ST_ABSENT;
            else begin
              state_d     = S_REM_LAST;
              rekey_ins_d = (stat_i.op == OP_REKEY);
            end
          end
          default: begin
            if (stat_i.empty) status_o = ST_EMPTY;
          end
        endcase
      end
      S_REM_LAST: begin
        cmd_o.rem_last_rd = 1'b1;
        // hole is the last slot: nothing moves
        if (stat_i.last_is_hole) state_d = rekey_ins_q ? S_INS : S_HEAD_RD;
        else                     state_d = S_REM_MOVE;
      end
      S_REM_MOVE: begin
        cmd_o.rem_move = 1'b1;
        cnt_d          = '0;
        state_d        = S_UP_RD;
      end
      S_INS: begin
        cmd_o.ins       = 1'b1;
        cmd_o.clr_moved = 1'b1;
        rekey_ins_d     = 1'b0;
        cnt_d           = '0;
        state_d         = S_UP_RD;
      end
      S_UP_RD: begin
        if (stat_i.up_at_root) begin
          state_d = S_UP_CMP;
        end else begin
          cmd_o.up_rd = 1'b1;
          cnt_d       = cnt_q + 2'd1;
          if (cnt_q == 2'd1) state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cnt_d = '0;
        if (!stat_i.up_at_root && stat_i.up_swap) begin
          cmd_o.up_step = 1'b1;
          state_d       = S_UP_RD;
        end else if (!ins_done_q && !stat_i.moved) begin
          // removal sift that did not rise continues downward
          state_d = S_DN_RD;
        end else begin
          // after a removal sift ends, rekey continues with insert
          state_d = rekey_ins_q ? S_INS : S_HEAD_RD;
        end
      end
      S_DN_RD: begin
        if (stat_i.dn_no_child) begin
          state_d = rekey_ins_q ? S_INS : S_HEAD_RD;
        end else begin
          cmd_o.dn_rd = 1'b1;
          cnt_d       = cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cnt_d = '0;
        if (stat_i.dn_swap) begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          state_d = rekey_ins_q ? S_INS : S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd1) begin
          cmd_o.set_result = 1'b1;
          cnt_d            = '0;
          state_d          = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // insert phase tracking: an insert sift never continues downward
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                          ins_done_q <= 1'b0;
    else if (cmd_o.latch_in)              ins_done_q <= 1'b0;
    else if (cmd_o.ins)                   ins_done_q <= 1'b1;
  end

  // a result is offered only from its own state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_OUT)
    else $error("result offered outside output state");
  // no new beat while work is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input and output open together");
  // insert and removal never issue in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ins && cmd_o.rem_last_rd))
    else $error("insert and remove collide");

endmodule

// ===== tb/sv/indexed_min_heap_timer_queue_test.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue_test: self-checking bench for the timer heap
// Drives insert / remove / rekey / expiry-check beats, predicts each result
// beat with a behavioral heap model and compares every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module indexed_min_heap_timer_queue_test;
  import imhtq_pkg::*;

  localparam int unsigned NTIM = 256;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [5:0]  pad;
    logic [63:0] now_ms;
    logic [63:0] trigger_time;
    logic [7:0]  tmr_id;
    op_e         operation;
  } op_beat_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [8:0]  count;
    logic        head_expired;
    logic [63:0] head_time;
    logic [7:0]  head_id;
    logic        head_valid;
    status_e     status;
  } head_beat_t;

  // directed row: expected result given only where obvious
  typedef struct {
    op_e         op;
    logic [7:0]  id;
    logic [63:0] trig;
    logic [63:0] now;
    bit          has_exp;
    status_e     st;
    logic [8:0]  cnt;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  always #5 clk_i = ~clk_i;

  indexed_min_heap_timer_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow heap state
  logic [7:0]  shadow_slot [NTIM];
  int unsigned shadow_pos  [NTIM];
  bit          shadow_live [NTIM];
  logic [63:0] shadow_time [NTIM];
  int unsigned shadow_cnt;

  head_beat_t  pending_heads[$];
  bit          fail_seen = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [63:0] key_of(int unsigned p);
    return shadow_time[shadow_slot[p]];
  endfunction

  function automatic void swap_pos(int unsigned a, int unsigned b);
    logic [7:0] ia;
    logic [7:0] ib;
    ia = shadow_slot[a];
    ib = shadow_slot[b];
    shadow_slot[a] = ib;
    shadow_slot[b] = ia;
    shadow_pos[ia] = b;
    shadow_pos[ib] = a;
  endfunction

  function automatic bit bubble_up(int unsigned p);
    bit moved;
    int unsigned par;
    moved = 0;
    while (p > 0) begin
      par = (p - 1) / 2;
      if (key_of(par) > key_of(p)) begin
        swap_pos(par, p);
        moved = 1;
        p = par;
      end else begin
        break;
      end
    end
    return moved;
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned c;
    forever begin
      c = 2 * p + 1;
      if (c >= shadow_cnt) return;
      if (c + 1 < shadow_cnt && key_of(c) > key_of(c + 1)) c++;
      if (key_of(p) > key_of(c)) begin
        swap_pos(p, c);
        p = c;
      end else begin
        return;
      end
    end
  endfunction

  function automatic void shadow_insert(logic [7:0] id, logic [63:0] t);
    bit dummy;
    shadow_time[id] = t;
    shadow_slot[shadow_cnt] = id;
    shadow_pos[id] = shadow_cnt;
    shadow_live[id] = 1;
    shadow_cnt++;
    dummy = bubble_up(shadow_cnt - 1);
  endfunction

  function automatic void shadow_remove(logic [7:0] id);
    int unsigned p;
    p = shadow_pos[id];
    shadow_live[id] = 0;
    shadow_cnt--;
    if (p >= shadow_cnt) return;
    shadow_slot[p] = shadow_slot[shadow_cnt];
    shadow_pos[shadow_slot[p]] = p;
    if (!bubble_up(p)) bubble_down(p);
  endfunction

  // apply one operation to the shadow heap and return the head beat
  function automatic head_beat_t apply_timer_op(op_beat_t b);
    head_beat_t r;
    r = '0;
    r.status = ST_OK;
    case (b.operation)
      OP_INSERT: begin
        if (shadow_cnt >= NTIM) r.status = ST_FULL;
        else if (shadow_live[b.tmr_id]) r.status = ST_PRESENT;
        else shadow_insert(b.tmr_id, b.trigger_time);
      end
      OP_REMOVE, OP_REKEY: begin
        if (shadow_cnt == 0) r.status = ST_EMPTY;
        else if (!shadow_live[b.tmr_id]) r.status = ST_ABSENT;
        else begin
          shadow_remove(b.tmr_id);
          if (b.operation == OP_REKEY) shadow_insert(b.tmr_id, b.trigger_time);
        end
      end
      default: begin
        if (shadow_cnt == 0) r.status = ST_EMPTY;
        else r.head_expired = (key_of(0) <= b.now_ms);
      end
    endcase
    if (shadow_cnt > 0) begin
      r.head_valid = 1'b1;
      r.head_id = shadow_slot[0];
      r.head_time = key_of(0);
    end
    r.count = shadow_cnt[8:0];
    return r;
  endfunction

  // send one beat; wait for handshake
  task automatic send_op(op_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    pending_heads.push_back(apply_timer_op(b));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_heads();
    s_axis_tvalid <= 1'b0;
    while (pending_heads.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_time(bit narrow);
    if (narrow) return 64'($urandom_range(40));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] live_or_any_id();
    int unsigned k;
    if (shadow_cnt != 0 && $urandom_range(99) < 85) begin
      k = $urandom_range(shadow_cnt - 1);
      return shadow_slot[k];
    end
    return 8'($urandom);
  endfunction

  // receiver: random stall, compare with oldest expectation
  always @(posedge clk_i) begin
    head_beat_t got;
    head_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_heads.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
          fail_seen = 1'b1;
        end else begin
          want = pending_heads.pop_front();
          if (got.status !== want.status || got.head_valid !== want.head_valid ||
              got.head_id !== want.head_id || got.head_time !== want.head_time ||
              got.head_expired !== want.head_expired || got.count !== want.count) begin
            $display("%0t: mismatch expected st=%0d v=%0b id=%0d t=%h x=%0b n=%0d",
                     $time, want.status, want.head_valid, want.head_id,
                     want.head_time, want.head_expired, want.count);
            $display("%0t:          actual   st=%0d v=%0b id=%0d t=%h x=%0b n=%0d",
                     $time, got.status, got.head_valid, got.head_id,
                     got.head_time, got.head_expired, got.count);
            fail_seen = 1'b1;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on beats accepted by either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_min_heap_timer_queue_test: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows [23];
    op_beat_t    b;
    head_beat_t  want;
    int unsigned phase;
    int unsigned n;
    bit          narrow;
    int unsigned r;

    for (int i = 0; i < NTIM; i++) begin
      shadow_live[i] = 0;
      shadow_slot[i] = '0;
      shadow_pos[i] = 0;
      shadow_time[i] = '0;
    end
    shadow_cnt = 0;

    // empty cases, extremes, duplicates, equal times, every operation
    rows = '{
      '{OP_CHECK,  8'd0,   64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_EMPTY, 9'd0},
      '{OP_REMOVE, 8'd5,   64'd0, 64'd0, 1, ST_EMPTY, 9'd0},
      '{OP_REKEY,  8'd255, 64'd7, 64'd0, 1, ST_EMPTY, 9'd0},
      '{OP_INSERT, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1, ST_OK, 9'd1},
      '{OP_INSERT, 8'd0,   64'd3, 64'd0, 1, ST_PRESENT, 9'd1},
      '{OP_CHECK,  8'd0,   64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 0, ST_OK, 9'd0},
      '{OP_CHECK,  8'd0,   64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, ST_OK, 9'd0},
      '{OP_INSERT, 8'd255, 64'd0, 64'd0, 1, ST_OK, 9'd2},
      '{OP_INSERT, 8'd170, 64'd0, 64'd0, 1, ST_OK, 9'd3},
      '{OP_INSERT, 8'd85,  64'd100, 64'd0, 1, ST_OK, 9'd4},
      '{OP_INSERT, 8'd1,   64'd50, 64'd0, 1, ST_OK, 9'd5},
      '{OP_REMOVE, 8'd9,   64'd0, 64'd0, 1, ST_ABSENT, 9'd5},
      '{OP_REKEY,  8'd9,   64'd1, 64'd0, 1, ST_ABSENT, 9'd5},
      '{OP_CHECK,  8'd0,   64'd0, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REMOVE, 8'd255, 64'd0, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REKEY,  8'd0,   64'd1, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REKEY,  8'd170, 64'hAAAA_5555_AAAA_5555, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REMOVE, 8'd1,   64'd0, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REMOVE, 8'd85,  64'd0, 64'd0, 0, ST_OK, 9'd0},
      '{OP_CHECK,  8'd0,   64'd0, 64'h5555_AAAA_5555_AAAA, 0, ST_OK, 9'd0},
      '{OP_REMOVE, 8'd0,   64'd0, 64'd0, 0, ST_OK, 9'd0},
      '{OP_REMOVE, 8'd170, 64'd0, 64'd0, 1, ST_OK, 9'd0},
      '{OP_CHECK,  8'd0,   64'd0, 64'd0, 1, ST_EMPTY, 9'd0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 47;

    // directed table
    foreach (rows[i]) begin
      b = '0;
      b.operation = rows[i].op;
      b.tmr_id = rows[i].id;
      b.trigger_time = rows[i].trig;
      b.now_ms = rows[i].now;
      send_op(b);
      want = pending_heads[$];
      if (rows[i].has_exp && (want.status !== rows[i].st || want.count !== rows[i].cnt)) begin
        $display("%0t: directed row %0d expected st=%0d n=%0d predicted st=%0d n=%0d",
                 $time, i, rows[i].st, rows[i].cnt, want.status, want.count);
        fail_seen = 1'b1;
      end
    end

    // random part: three idle phases, then fill to full and drain
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      narrow = (phase == 1);
      for (n = 0; n < 320; n++) begin
        b = '0;
        r = $urandom_range(99);
        if (r < 45 - (shadow_cnt > 40 ? 20 : 0)) begin
          b.operation = OP_INSERT;
          b.tmr_id = ($urandom_range(9) == 0) ? live_or_any_id() : 8'($urandom);
        end else if (r < 70) begin
          b.operation = OP_REMOVE;
          b.tmr_id = live_or_any_id();
        end else if (r < 88) begin
          b.operation = OP_REKEY;
          b.tmr_id = live_or_any_id();
        end else begin
          b.operation = OP_CHECK;
          b.tmr_id = 8'($urandom);
        end
        b.trigger_time = rand_time(narrow);
        b.now_ms = ($urandom_range(1) && shadow_cnt != 0) ?
                   key_of(0) + 64'($urandom_range(2)) - 64'd1 : rand_time(narrow);
        send_op(b);
      end
      // hold off until every result has come back
      drain_heads();
    end

    // fill the heap completely, poke full, then empty it
    for (int i = 0; i < NTIM; i++) begin
      b = '0;
      b.operation = OP_INSERT;
      b.tmr_id = 8'(i);
      b.trigger_time = rand_time(1'($urandom_range(1)));
      send_op(b);
    end
    for (int i = 0; i < 4; i++) begin
      b = '0;
      b.operation = (i < 2) ? OP_INSERT : (i == 2 ? OP_REKEY : OP_CHECK);
      b.tmr_id = 8'($urandom);
      b.trigger_time = rand_time(0);
      b.now_ms = rand_time(0);
      send_op(b);
    end
    while (shadow_cnt != 0) begin
      b = '0;
      b.operation = ($urandom_range(3) == 0) ? OP_CHECK : OP_REMOVE;
      b.tmr_id = live_or_any_id();
      b.now_ms = rand_time(0);
      send_op(b);
    end

    drain_heads();
    if (!fail_seen) begin
      $display("indexed_min_heap_timer_queue_test: PASS");
    end else begin
      $display("indexed_min_heap_timer_queue_test: FAIL");
    end
    $finish;
  end

endmodule
